@@ hdl/scbp_pkg.sv @@
// Shared types and constants of the size-class block pool.
package scbp_pkg;

  // Parameter defaults
  localparam int unsigned NUM_CLASSES_DEF = 32'd16;
  localparam int unsigned STACK_DEPTH_DEF = 32'd64;
  localparam int unsigned HANDLE_BITS_DEF = 32'd32;
  localparam int unsigned WORD_BYTES_DEF  = 32'd8;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_MIN_EXP = 2'd0;
  localparam logic [1:0] CFG_CLASSES = 2'd1;
  localparam logic [4:0] MIN_EXP_RST = 5'd12;
  localparam logic [4:0] CLASSES_RST = 5'd16;

  // Request functions
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Width of the folded size remainder sum and its reciprocal shift
  localparam int unsigned FOLD_W      = 11;
  localparam int unsigned RECIP_SHIFT = FOLD_W + 5;

  typedef enum logic [2:0] {
    OC_HIT        = 3'd0,
    OC_EMPTY      = 3'd1,
    OC_OVER_ALLOC = 3'd2,
    OC_PUSHED     = 3'd3,
    OC_OVER_FREE  = 3'd4,
    OC_FULL       = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CLASS = 2'd1,
    ST_LOOK  = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic        func;
    logic [31:0] request_size;
    logic [31:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [31:0] handle_out;
    logic [2:0]  outcome;
    logic [32:0] fallback_bytes;
    logic [4:0]  class_index;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic classify;
    logic lookup;
    logic respond;
  } ctrl_t;

endpackage

@@ hdl/scbp_ctrl.sv @@
// Sequencing state machine of the size-class block pool.
module scbp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output scbp_pkg::ctrl_t      ctrl_o
);
  import scbp_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign take = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_CLASS;
      ST_CLASS: state_d = ST_LOOK;
      ST_LOOK:  state_d = ST_DONE;
      ST_DONE:  state_d = start_i ? ST_CLASS : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o          = 1'b0;
    ctrl_o.classify = 1'b0;
    ctrl_o.lookup   = 1'b0;
    ctrl_o.respond  = 1'b0;
    case (state_q)
      ST_IDLE:  busy_o = 1'b0;
      ST_CLASS: begin
        busy_o          = 1'b1;
        ctrl_o.classify = 1'b1;
      end
      ST_LOOK: begin
        busy_o        = 1'b1;
        ctrl_o.lookup = 1'b1;
      end
      ST_DONE:  ctrl_o.respond = 1'b1;
      default:  busy_o = 1'b0;
    endcase
    ctrl_o.load = take;
  end

endmodule

@@ hdl/scbp_dp.sv @@
// Datapath of the size-class block pool: classing, fill counts, stack memory.
module scbp_dp #(
  parameter int unsigned NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
  parameter int unsigned STACK_DEPTH = scbp_pkg::STACK_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = scbp_pkg::HANDLE_BITS_DEF,
  parameter int unsigned WORD_BYTES  = scbp_pkg::WORD_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scbp_pkg::ctrl_t  ctrl_i,
  input  scbp_pkg::req_t   req_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [4:0]       cfg_data_i,
  output scbp_pkg::rsp_t   rsp_o
);
  import scbp_pkg::*;

  localparam int unsigned DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned FW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SW    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int unsigned PW    = FOLD_W + RECIP_SHIFT + 1;
  localparam int unsigned RECIP = ((1 << RECIP_SHIFT) + WORD_BYTES - 1) / WORD_BYTES;
  // Weight of each size nibble modulo the word size
  localparam int unsigned NIB_W [8] = '{
    1 % WORD_BYTES, 16 % WORD_BYTES, 256 % WORD_BYTES, 4096 % WORD_BYTES,
    65536 % WORD_BYTES, 1048576 % WORD_BYTES, 16777216 % WORD_BYTES,
    268435456 % WORD_BYTES
  };

  req_t              req_q;
  logic [4:0]        min_exp_q, classes_q;
  logic [5:0]        exp_q, exp_d;
  logic [FOLD_W-1:0] fold_q, fold_d;
  logic [FOLD_W-1:0] quot_q, quot_d;
  logic [FW-1:0]     fill_q [NUM_CLASSES];
  logic [SW-1:0]     mem [DEPTH];
  logic [SW-1:0]     rdata_q;
  logic [2:0]        outcome_q, outcome_d;
  logic [4:0]        cidx_q, cidx_d;
  logic [5:0]        zone_q, zone_d;

  logic [5:0]        idx, served;
  logic [CW-1:0]     idx_sel;
  logic              over, pop, push;
  logic [FW-1:0]     fill_cur, offset;
  logic [AW-1:0]     addr;
  logic [PW-1:0]     prod;
  logic [FOLD_W-1:0] rem_full;
  logic [4:0]        rem;
  logic [32:0]       size_ext;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_exp_q <= MIN_EXP_RST;
      classes_q <= CLASSES_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MIN_EXP) min_exp_q <= cfg_data_i;
      if (cfg_index_i == CFG_CLASSES) classes_q <= cfg_data_i;
    end
  end

  // Classify: ceil(log2(size)) and the size folded modulo the word size
  always_comb begin
    logic [31:0] v;
    v     = req_q.request_size - 32'd1;
    exp_d = 6'd0;
    if (req_q.request_size > 32'd1) begin
      for (int i = 0; i < 32; i++) begin
        if (v[i]) exp_d = 6'(i + 1);
      end
    end
    fold_d = '0;
    for (int i = 0; i < 8; i++) begin
      fold_d = fold_d + FOLD_W'(req_q.request_size[4*i +: 4]) * FOLD_W'(NIB_W[i]);
    end
  end

  // Lookup: class index, serve check, outcome, fill count, stack address and fold quotient
  always_comb begin
    zone_d   = (exp_q < {1'b0, min_exp_q}) ? {1'b0, min_exp_q} : exp_q;
    idx      = zone_d - {1'b0, min_exp_q};
    served   = ({1'b0, classes_q} < 6'(NUM_CLASSES)) ? {1'b0, classes_q} : 6'(NUM_CLASSES);
    over     = idx >= served;
    idx_sel  = idx[CW-1:0];
    fill_cur = over ? '0 : fill_q[idx_sel];
    cidx_d   = (idx > 6'd31) ? 5'd31 : idx[4:0];
    pop      = 1'b0;
    push     = 1'b0;
    if (over) begin
      outcome_d = (req_q.func == FUNC_ALLOC) ? OC_OVER_ALLOC : OC_OVER_FREE;
    end else if (req_q.func == FUNC_ALLOC) begin
      if (fill_cur == '0) begin
        outcome_d = OC_EMPTY;
      end else begin
        outcome_d = OC_HIT;
        pop       = 1'b1;
      end
    end else begin
      if (fill_cur >= FW'(STACK_DEPTH)) begin
        outcome_d = OC_FULL;
      end else begin
        outcome_d = OC_PUSHED;
        push      = 1'b1;
      end
    end
    offset = pop ? fill_cur - 1'b1 : fill_cur;
    addr   = AW'(idx_sel) * AW'(STACK_DEPTH) + AW'(offset);
    prod   = PW'(fold_q) * PW'(RECIP);
    quot_d = prod[RECIP_SHIFT +: FOLD_W];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) req_q <= req_i;
    if (ctrl_i.classify) begin
      exp_q  <= exp_d;
      fold_q <= fold_d;
    end
    if (ctrl_i.lookup) begin
      outcome_q <= outcome_d;
      cidx_q    <= cidx_d;
      zone_q    <= zone_d;
      quot_q    <= quot_d;
    end
  end

  // Fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) fill_q[i] <= '0;
    end else if (ctrl_i.lookup) begin
      if (pop)  fill_q[idx_sel] <= fill_cur - 1'b1;
      if (push) fill_q[idx_sel] <= fill_cur + 1'b1;
    end
  end

  // Class stack memory
  always_ff @(posedge clk_i) begin
    if (ctrl_i.lookup && push) mem[addr] <= req_q.handle_in[SW-1:0];
    if (ctrl_i.lookup && pop)  rdata_q   <= mem[addr];
  end

  // Respond: result fields, class-size fallback, and an oversized size rounded up to whole words
  always_comb begin
    rem_full = fold_q - FOLD_W'(quot_q * FOLD_W'(WORD_BYTES));
    rem      = rem_full[4:0];
    size_ext = {1'b0, req_q.request_size};
    rsp_o.outcome        = outcome_q;
    rsp_o.class_index    = cidx_q;
    rsp_o.handle_out     = (outcome_q == OC_HIT) ? 32'(rdata_q) : 32'd0;
    rsp_o.fallback_bytes = 33'd0;
    case (outcome_q)
      OC_EMPTY:      rsp_o.fallback_bytes = 33'd1 << zone_q;
      OC_OVER_ALLOC: rsp_o.fallback_bytes = (rem == 5'd0) ? size_ext
                                          : size_ext + 33'(WORD_BYTES) - 33'(rem);
      default:       rsp_o.fallback_bytes = 33'd0;
    endcase
  end

endmodule

@@ hdl/size_class_block_pool.sv @@
// Top level of the size-class block pool.
//
// Pool of block handles sorted into power-of-two size classes, each class a
// LIFO stack in one shared single-port memory. Assert start with a request
// while busy is low; the request transfers on that edge. The result shows on
// rsp_o, flagged by done_o for exactly one cycle, once the transfer has gone
// through the controller states: ST_CLASS works out the class (a ceil-log2
// over the 32-bit size and a fold of the size modulo the word size), ST_LOOK
// reads or writes the class stack memory and updates the class fill count,
// and ST_DONE presents the result. The receiver has no way to stall, so
// capture rsp_o whenever done_o is high. busy is low while the result shows,
// so a new request may transfer in that cycle, but none is taken while the
// class and lookup states are under way. Stacks need no clearing after reset;
// an entry is read only once it has been pushed. Configuration writes are
// taken every cycle (cfg_ready_o is always high) and belong between requests.
module size_class_block_pool #(
  parameter int unsigned NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
  parameter int unsigned STACK_DEPTH = scbp_pkg::STACK_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = scbp_pkg::HANDLE_BITS_DEF,
  parameter int unsigned WORD_BYTES  = scbp_pkg::WORD_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  scbp_pkg::req_t  req_i,
  output logic            done_o,
  output scbp_pkg::rsp_t  rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [4:0]      cfg_data_i
);
  import scbp_pkg::*;

  ctrl_t ctrl;

  // Config writes never wait
  assign cfg_ready_o = 1'b1;
  // Result strobe: high only in the present cycle
  assign done_o = ctrl.respond;

  scbp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .ctrl_o  (ctrl)
  );

  scbp_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .WORD_BYTES  (WORD_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o)
  );

endmodule

@@ hdl/scbp_checker.sv @@
// Port-level checks of the size-class block pool, bound to the top level.
module scbp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input scbp_pkg::rsp_t rsp_o
);
  import scbp_pkg::*;

  // A transfer yields its result once the class and lookup states are through
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result missing three cycles after request transfer");

  // The block is open for a request while a result shows
  a_open_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy while result shows");

  // Handle only on a pool hit
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.outcome != OC_HIT) |-> rsp_o.handle_out == 32'd0)
    else $error("handle on a non-hit result");

  // Fallback bytes only on a fallback allocation
  a_fallback_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.outcome != OC_EMPTY && rsp_o.outcome != OC_OVER_ALLOC)
      |-> rsp_o.fallback_bytes == 33'd0)
    else $error("fallback bytes without fallback");

endmodule

bind size_class_block_pool scbp_checker u_scbp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

@@ bench/tb_top.sv @@
// Self-checking testbench for the size-class block pool: directed and random requests.
`timescale 1ns / 100ps

module tb_top;
  import scbp_pkg::*;

  localparam int unsigned NUM_CLASSES = NUM_CLASSES_DEF;
  localparam int unsigned STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned WORD_BYTES  = WORD_BYTES_DEF;

  // Register indexes the block decodes to nothing
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  // How the request side spaces its transfers
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_RANDOM = 1;
  localparam int IDLE_MIXED  = 2;

  typedef struct {
    req_t        req;
    int unsigned gap;
  } pending_t;

  typedef struct {
    logic [4:0] min_exp;
    logic [4:0] classes;
    int         items;
    int         free_pct;
    int         idle;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  req_t       req = '0;
  logic       done;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_MIN_EXP;
  logic [4:0] cfg_data = '0;

  // Shadow copy of the pool: per-class handle stacks, fill counts and registers
  logic [31:0] shadow_stack [NUM_CLASSES][STACK_DEPTH];
  int unsigned shadow_fill [NUM_CLASSES];
  logic [4:0]  shadow_min_exp = MIN_EXP_RST;
  logic [4:0]  shadow_classes = CLASSES_RST;

  pending_t    req_queue [$];
  rsp_t        due_rsps [$];
  int unsigned reqs_queued = 0;
  int unsigned rsps_checked = 0;
  int unsigned waited = 0;
  int          idle_style = IDLE_RANDOM;
  bit          failed = 1'b0;

  size_class_block_pool dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow pool and return the result the block owes.
  function automatic rsp_t pool_apply(req_t r);
    rsp_t        res;
    int unsigned expo;
    int unsigned zone;
    int unsigned idx;
    int unsigned served;
    logic [31:0] v;
    logic [63:0] rounded;
    res = '0;
    // ceil(log2(size)) is the bit length of size - 1; sizes 0 and 1 give 0
    expo = 0;
    if (r.request_size > 32'd1) begin
      v = r.request_size - 32'd1;
      while (v != 0) begin
        expo++;
        v = v >> 1;
      end
    end
    zone = (expo < shadow_min_exp) ? int'(shadow_min_exp) : expo;
    idx = zone - shadow_min_exp;
    served = (shadow_classes < NUM_CLASSES) ? int'(shadow_classes) : NUM_CLASSES;
    res.class_index = (idx > 31) ? 5'd31 : idx[4:0];
    if (idx >= served) begin
      // Not served from the pool: allocs fall back with the word-rounded size
      if (r.func == FUNC_ALLOC) begin
        res.outcome = OC_OVER_ALLOC;
        rounded = (64'(r.request_size) + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
        res.fallback_bytes = rounded[32:0];
      end else begin
        res.outcome = OC_OVER_FREE;
      end
    end else if (r.func == FUNC_ALLOC) begin
      if (shadow_fill[idx] == 0) begin
        // Empty class: fall back with the full class size, up to 2^32
        res.outcome = OC_EMPTY;
        res.fallback_bytes = 33'd1 << zone;
      end else begin
        shadow_fill[idx]--;
        res.handle_out = shadow_stack[idx][shadow_fill[idx]];
        res.outcome = OC_HIT;
      end
    end else begin
      if (shadow_fill[idx] >= STACK_DEPTH) begin
        res.outcome = OC_FULL;
      end else begin
        shadow_stack[idx][shadow_fill[idx]] = r.handle_in;
        shadow_fill[idx]++;
        res.outcome = OC_PUSHED;
      end
    end
    return res;
  endfunction

  // Request driver: hold start until the transfer, then launch the next item
  // once its idle gap has run out. start gets at most one assignment per edge.
  always @(posedge clk or negedge rst_n) begin : drive_req
    pending_t nxt;
    if (!rst_n) begin
      start  <= 1'b0;
      req    <= '0;
      waited <= 0;
    end else begin
      if (start && !busy) begin
        due_rsps.push_back(pool_apply(req));
      end
      if (start && busy) begin
        // hold the request until the block takes it
      end else if (req_queue.size() != 0 && waited >= req_queue[0].gap) begin
        nxt = req_queue[0];
        req_queue.delete(0);
        req    <= nxt.req;
        start  <= 1'b1;
        waited <= 0;
      end else begin
        start <= 1'b0;
        if (req_queue.size() != 0) begin
          waited <= waited + 1;
        end
      end
    end
  end

  // Result monitor: a result is valid for exactly one cycle, so take it on
  // every edge that sees done high and compare it with the oldest prediction.
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (rst_n && done) begin
      rsps_checked++;
      if (due_rsps.size() == 0) begin
        $display("%0t: unexpected result, none predicted, actual %h", $time, rsp);
        failed = 1'b1;
      end else begin
        want = due_rsps[0];
        due_rsps.delete(0);
        if (rsp.handle_out !== want.handle_out) begin
          $display("%0t: handle_out expected %h actual %h", $time,
                   want.handle_out, rsp.handle_out);
          failed = 1'b1;
        end
        if (rsp.outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time,
                   want.outcome, rsp.outcome);
          failed = 1'b1;
        end
        if (rsp.fallback_bytes !== want.fallback_bytes) begin
          $display("%0t: fallback_bytes expected %h actual %h", $time,
                   want.fallback_bytes, rsp.fallback_bytes);
          failed = 1'b1;
        end
        if (rsp.class_index !== want.class_index) begin
          $display("%0t: class_index expected %0d actual %0d", $time,
                   want.class_index, rsp.class_index);
          failed = 1'b1;
        end
      end
    end
  end

  // Queue one request with an idle gap drawn in the current style.
  task automatic queue_req(input logic func, input logic [31:0] size,
                           input logic [31:0] handle);
    pending_t item;
    item.req.func = func;
    item.req.request_size = size;
    item.req.handle_in = handle;
    case (idle_style)
      IDLE_NONE:   item.gap = 0;
      IDLE_RANDOM: item.gap = $urandom_range(0, 19);
      default:     item.gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
    endcase
    req_queue.push_back(item);
    reqs_queued++;
  endtask

  // Random request aimed mostly at the served classes and the first one above.
  task automatic queue_random(input int free_pct);
    logic        func;
    int unsigned served;
    int unsigned tgt;
    int unsigned expo;
    int unsigned pick;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] sz;
    func = ($urandom_range(0, 99) < free_pct) ? FUNC_FREE : FUNC_ALLOC;
    served = (shadow_classes < NUM_CLASSES) ? int'(shadow_classes) : NUM_CLASSES;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      sz = $urandom;
    end else if (pick < 12) begin
      case ($urandom_range(0, 4))
        0:       sz = 0;
        1:       sz = 1;
        2:       sz = 64'hFFFF_FFFF;
        3:       sz = 64'h8000_0000;
        default: sz = 64'h8000_0001;
      endcase
    end else begin
      tgt = $urandom_range(0, served);
      // every size at or below the smallest class lands in class zero
      expo = (tgt == 0) ? $urandom_range(0, shadow_min_exp) : shadow_min_exp + tgt;
      if (expo > 32) begin
        expo = $urandom_range(0, 32);
      end
      if (expo == 0) begin
        sz = $urandom_range(0, 1);
      end else begin
        lo = (64'd1 << (expo - 1)) + 1;
        hi = 64'd1 << expo;
        if (hi > 64'hFFFF_FFFF) begin
          hi = 64'hFFFF_FFFF;
        end
        if ($urandom_range(0, 3) == 0) begin
          sz = hi;
        end else begin
          sz = lo + ({$urandom, $urandom} % (hi - lo + 1));
        end
      end
    end
    queue_req(func, sz[31:0], $urandom);
  endtask

  // Wait until every queued request has produced its result, then let the
  // pipeline settle before touching the registers.
  task automatic wait_drained();
    while (rsps_checked < reqs_queued) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
  endtask

  // Register write over the configuration channel; track it in the shadow.
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_EXP: shadow_min_exp = val;
      CFG_CLASSES: shadow_classes = val;
      default:     ;
    endcase
  endtask

  initial begin : stimulus
    phase_t plan [9];
    int     p;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      shadow_fill[c] = 0;
    end
    // Each phase: min exponent, classes in use, items, percent frees, idling
    plan = '{
      '{5'd12, 5'd16, 200, 60, IDLE_RANDOM},
      '{5'd3,  5'd1,  200, 85, IDLE_NONE},
      '{5'd0,  5'd31, 250, 50, IDLE_MIXED},
      '{5'd31, 5'd0,  100, 50, IDLE_RANDOM},
      '{5'd31, 5'd2,  150, 70, IDLE_NONE},
      '{5'd20, 5'd4,  250, 40, IDLE_MIXED},
      '{5'd8,  5'd16, 300, 65, IDLE_RANDOM},
      '{5'd5,  5'd3,  200, 80, IDLE_MIXED},
      '{5'd12, 5'd16, 150, 30, IDLE_NONE}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: smallest class is 4 KiB, 16 served.
    idle_style = IDLE_MIXED;
    queue_req(FUNC_ALLOC, 32'd0, 32'd0);                     // empty class zero
    queue_req(FUNC_ALLOC, 32'd1, 32'd0);
    queue_req(FUNC_FREE,  32'd0, 32'hFFFF_FFFF);             // push all-ones handle
    queue_req(FUNC_FREE,  32'd4096, 32'h0000_0000);          // push zero handle
    queue_req(FUNC_ALLOC, 32'd4096, 32'h1234_5678);          // LIFO: zero first
    queue_req(FUNC_ALLOC, 32'd4095, 32'd0);                  // odd size, same class
    queue_req(FUNC_ALLOC, 32'd2, 32'd0);
    queue_req(FUNC_FREE,  32'd4097, 32'hA5A5_A5A5);          // just over a power of two
    queue_req(FUNC_FREE,  32'd8192, 32'h5A5A_5A5A);
    queue_req(FUNC_ALLOC, 32'd8191, 32'd0);
    queue_req(FUNC_ALLOC, 32'd4097, 32'd0);
    queue_req(FUNC_ALLOC, 32'h0800_0000, 32'd0);             // top served class, empty
    queue_req(FUNC_FREE,  32'h0800_0000, 32'h1234_5678);
    queue_req(FUNC_ALLOC, 32'h0800_0000, 32'd0);
    queue_req(FUNC_ALLOC, 32'h0800_0001, 32'd0);             // first oversized class
    queue_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);             // rounds up to 2^32
    queue_req(FUNC_FREE,  32'hFFFF_FFFF, 32'hDEAD_BEEF);     // oversized free
    queue_req(FUNC_ALLOC, 32'h8000_0000, 32'd0);
    queue_req(FUNC_ALLOC, 32'h8000_0001, 32'd0);
    queue_req(FUNC_ALLOC, 32'd7, 32'd0);
    queue_req(FUNC_FREE,  32'd3, 32'h0000_0000);
    queue_req(FUNC_ALLOC, 32'd5, 32'hFFFF_FFFF);             // handle_in ignored
    wait_drained();

    // Writes to the undecoded indexes must leave the settings alone.
    write_reg(CFG_SPARE_2, 5'h1F);
    write_reg(CFG_SPARE_3, 5'h15);
    idle_style = IDLE_RANDOM;
    repeat (30) queue_random(50);
    wait_drained();

    for (p = 0; p < 9; p++) begin
      write_reg(CFG_MIN_EXP, plan[p].min_exp);
      write_reg(CFG_CLASSES, plan[p].classes);
      idle_style = plan[p].idle;
      // Open with the largest sizes: wide class index at a zero minimum,
      // 2^32 fallback when the top exponent is a served class.
      queue_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);
      queue_req(FUNC_FREE, 32'h8000_0001, $urandom);
      repeat (plan[p].items) queue_random(plan[p].free_pct);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (due_rsps.size() != 0) begin
      $display("%0t: %0d predicted results never arrived, oldest expected %h",
               $time, due_rsps.size(), due_rsps[0]);
      failed = 1'b1;
    end
    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d of %0d results checked", $time, rsps_checked, reqs_queued);
    $display("Test completed with failures");
    $finish;
  end

endmodule
